>>> hdl/stbs_pkg.sv
`default_nettype none

package stbs_pkg;

	// Default table depth; the top level hands its parameter down from here.
	localparam int unsigned DEFAULT_TABLE_DEPTH = 512;

	// Fixed port widths of the block.
	localparam int unsigned KEY_W   = 32;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned INDEX_W = 9;
	localparam int unsigned COUNT_W = 10;

	// Command codes on the cmd port.
	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;

	// One table entry as it lives in the memory.
	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} entry_t;

endpackage

`default_nettype wire

>>> hdl/stbs_table.sv
`default_nettype none

// Single-port-write, single-port-read table memory with registered read data.
module stbs_table #(
	parameter int unsigned DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH,
	parameter int unsigned AW    = $clog2(stbs_pkg::DEFAULT_TABLE_DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire stbs_pkg::entry_t wr_entry,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output stbs_pkg::entry_t      rd_entry
);

	stbs_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_entry <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/sorted_table_binary_search.sv
`default_nettype none

// Key/value table searched by binary search over a sorted range of entries.
// Input channel: an item transfers at a rising edge where start is high and
// busy is low. cmd selects a write (store key and entry_value at entry_index,
// ignored when entry_index is outside the table) or a lookup of key over the
// first entry_count entries. A write gives no result;
// busy stays low, so writes may follow each other in every cycle.
// Result channel: each lookup gives one result, shown for exactly one cycle
// with done high; found tells whether the key matched and result_value carries
// the stored value (zero on a miss). The receiver cannot stall the block.
// Lookup: a lookup that makes P probes issues its first read in the
// transfer cycle; each probe resolves from the registered read data of its
// read, the last one loading the result. P is at most log2(TABLE_DEPTH)+1
// (ten for 512 entries); an entry_count of zero answers not found with no
// probe. busy stays high until the lookup ends, so a new item waits; one may
// transfer in the cycle done is high. The user sets entry_count via cfg_we/
// cfg_wdata only while the block is idle; the block does not enforce it.
// Reset clears the search control and entry_count; the table contents are
// undefined until written, and no clearing pass is made.
module sorted_table_binary_search #(
	parameter int unsigned TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          cmd,
	input  wire logic [stbs_pkg::INDEX_W-1:0]  entry_index,
	input  wire logic [stbs_pkg::KEY_W-1:0]    key,
	input  wire logic [stbs_pkg::VALUE_W-1:0]  entry_value,
	output logic                               done,
	output logic                               found,
	output logic [stbs_pkg::VALUE_W-1:0]       result_value,
	input  wire logic                          cfg_we,
	input  wire logic [stbs_pkg::COUNT_W-1:0]  cfg_wdata
);

	// Address width of the table, width of the search bounds (which must
	// reach TABLE_DEPTH itself), and compare widths for the range checks.
	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned IW = (CW > stbs_pkg::INDEX_W) ? CW : stbs_pkg::INDEX_W;
	localparam int unsigned LW = (CW > stbs_pkg::COUNT_W) ? CW : stbs_pkg::COUNT_W;

	typedef enum logic {
		ST_IDLE,
		ST_SEARCH
	} state_t;

	state_t                          state_q;
	logic [stbs_pkg::COUNT_W-1:0]    entry_count_q;

	// Search interval [lo, hi) and the slot whose read is in flight.
	logic [CW-1:0]                   lo_q;
	logic [CW-1:0]                   hi_q;
	logic [CW-1:0]                   mid_q;
	logic [stbs_pkg::KEY_W-1:0]      key_q;

	stbs_pkg::entry_t                wr_entry;
	stbs_pkg::entry_t                rd_entry;
	logic                            wr_en;
	logic                            rd_en;
	logic [AW-1:0]                   rd_addr;

	logic                            in_xfer;
	logic                            index_ok;
	logic [LW-1:0]                   count_ext;
	logic [LW-1:0]                   limit;
	logic [CW-1:0]                   hi_start;

	logic                            hit;
	logic                            go_up;
	logic [CW-1:0]                   lo_up;
	logic                            up_empty;
	logic                            down_empty;
	logic [CW-1:0]                   mid_up;
	logic [CW-1:0]                   mid_down;
	logic [CW-1:0]                   next_mid;

	assign busy    = (state_q == ST_SEARCH);
	assign in_xfer = start && !busy;

	// Writes go straight into the table; slots beyond the table are dropped.
	assign index_ok       = IW'(entry_index) < IW'(TABLE_DEPTH);
	assign wr_en          = in_xfer && (cmd == stbs_pkg::CMD_WRITE) && index_ok;
	assign wr_entry.key   = key;
	assign wr_entry.value = entry_value;

	// The searched range never extends past the end of the table.
	assign count_ext = LW'(entry_count_q);
	assign limit     = (count_ext > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH) : count_ext;
	assign hi_start  = CW'(limit);

	// Probe outcome. Both possible next midpoints are formed in parallel with
	// the key compare, so only a select follows it on the way to the address.
	assign hit        = (rd_entry.key == key_q);
	assign go_up      = (rd_entry.key < key_q);
	assign lo_up      = mid_q + CW'(1);
	assign up_empty   = (lo_up >= hi_q);
	assign down_empty = (lo_q >= mid_q);
	assign mid_up     = lo_up + ((hi_q - lo_up) >> 1);
	assign mid_down   = lo_q + ((mid_q - lo_q) >> 1);
	assign next_mid   = go_up ? mid_up : mid_down;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = AW'(hi_start >> 1);
		unique case (state_q)
			ST_IDLE: begin
				rd_en   = in_xfer && (cmd == stbs_pkg::CMD_LOOKUP) && (hi_start != '0);
				rd_addr = AW'(hi_start >> 1);
			end
			ST_SEARCH: begin
				rd_en   = !hit && (go_up ? !up_empty : !down_empty);
				rd_addr = AW'(next_mid);
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = AW'(hi_start >> 1);
			end
		endcase
	end

	stbs_table #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_table (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (AW'(entry_index)),
		.wr_entry (wr_entry),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	// Control state and the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done         <= 1'b0;
			found        <= 1'b0;
			result_value <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer && (cmd == stbs_pkg::CMD_LOOKUP)) begin
						if (hi_start == '0) begin
							// Empty range: nothing to probe.
							done         <= 1'b1;
							found        <= 1'b0;
							result_value <= '0;
						end else begin
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (hit) begin
						state_q      <= ST_IDLE;
						done         <= 1'b1;
						found        <= 1'b1;
						result_value <= rd_entry.value;
					end else if (go_up ? up_empty : down_empty) begin
						state_q      <= ST_IDLE;
						done         <= 1'b1;
						found        <= 1'b0;
						result_value <= '0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Search bounds follow the probe that is being resolved.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			lo_q  <= '0;
			hi_q  <= hi_start;
			mid_q <= hi_start >> 1;
			key_q <= key;
		end else if (go_up) begin
			lo_q  <= lo_up;
			mid_q <= mid_up;
		end else begin
			hi_q  <= mid_q;
			mid_q <= mid_down;
		end
	end

endmodule

`default_nettype wire
